// File: rtl/quoted_brace_word_tokenizer_assert.svh
// assertion macros for the word tokenizer checker
`ifndef QUOTED_BRACE_WORD_TOKENIZER_ASSERT_SVH
`define QUOTED_BRACE_WORD_TOKENIZER_ASSERT_SVH

// clocked assertion, idle while reset is held
`define QBWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form of the same
`define QBWT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/qbwt_pkg.sv
// types and character codes shared by the word tokenizer modules
package qbwt_pkg;

	// character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// input transaction
	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_line;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic       kind;
		logic [7:0] char_out;
		logic       token_quoted;
		logic       last_of_run;
	} out_item_t;

	// classified work for the back part
	typedef struct packed {
		logic       has_char;
		logic [7:0] ch;
		logic       has_end;
		logic       quoted;
	} qbwt_entry_t;

endpackage

// File: rtl/qbwt_front.sv
// front part: grouping state, character classification, queue entry build
module qbwt_front import qbwt_pkg::*; #(
	parameter int MAX_BRACE_DEPTH = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  in_item_t    item,
	input  logic        full,
	output logic        push,
	output qbwt_entry_t entry
);

	localparam int BW = $clog2(MAX_BRACE_DEPTH + 1);
	localparam logic [BW-1:0] BR_MAX = BW'(MAX_BRACE_DEPTH);

	logic          sq_q, dq_q, open_q, wq_q;
	logic [BW-1:0] br_q;
	logic          sq_d, dq_d, open_d, wq_d;
	logic [BW-1:0] br_d;
	logic          emit_char, emit_end, close_tok, accept;
	logic [7:0]    c;
	logic          eol;

	assign c      = item.char_in;
	assign eol    = item.end_of_line;
	assign stall  = full;
	assign accept = valid && !full;

	// next grouping state and what this character emits
	always_comb begin
		sq_d      = sq_q;
		dq_d      = dq_q;
		br_d      = br_q;
		open_d    = open_q;
		wq_d      = wq_q;
		emit_char = 1'b0;
		emit_end  = 1'b0;
		if (sq_q) begin
			if (c == CH_SQUOTE) sq_d = 1'b0;
			else emit_char = 1'b1;
		end else if (dq_q) begin
			if (c == CH_DQUOTE) dq_d = 1'b0;
			else emit_char = 1'b1;
		end else if (br_q != '0) begin
			if (c == CH_LBRACE) begin
				if (br_q < BR_MAX) br_d = br_q + 1'b1;
				emit_char = 1'b1;
			end else if (c == CH_RBRACE) begin
				br_d      = br_q - 1'b1;
				emit_char = (br_q != BW'(1));
			end else begin
				emit_char = 1'b1;
			end
		end else if (c == CH_SQUOTE) begin
			sq_d   = 1'b1;
			wq_d   = 1'b1;
			open_d = 1'b1;
		end else if (c == CH_DQUOTE) begin
			dq_d   = 1'b1;
			wq_d   = 1'b1;
			open_d = 1'b1;
		end else if (c == CH_LBRACE) begin
			br_d   = BW'(1);
			wq_d   = 1'b1;
			open_d = 1'b1;
		end else if (c inside {CH_SPACE, CH_TAB}) begin
			emit_end = open_q;
		end else begin
			emit_char = 1'b1;
			open_d    = 1'b1;
		end

		close_tok = emit_end || (eol && open_d);

		entry.has_char = emit_char;
		entry.ch       = c;
		entry.has_end  = close_tok;
		entry.quoted   = wq_d;

		if (close_tok) begin
			open_d = 1'b0;
			wq_d   = 1'b0;
		end
		// end of line clears everything
		if (eol) begin
			sq_d   = 1'b0;
			dq_d   = 1'b0;
			br_d   = '0;
			open_d = 1'b0;
			wq_d   = 1'b0;
		end
	end

	// only characters that produce results enter the queue
	assign push = accept && (emit_char || close_tok);

	// grouping state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q   <= 1'b0;
			dq_q   <= 1'b0;
			br_q   <= '0;
			open_q <= 1'b0;
			wq_q   <= 1'b0;
		end else if (accept) begin
			sq_q   <= sq_d;
			dq_q   <= dq_d;
			br_q   <= br_d;
			open_q <= open_d;
			wq_q   <= wq_d;
		end
	end

endmodule

// File: rtl/qbwt_queue.sv
// short queue of classified entries between front and back
module qbwt_queue import qbwt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  qbwt_entry_t wr_entry,
	input  logic        pop,
	output qbwt_entry_t head,
	output logic        empty,
	output logic        full
);

	qbwt_entry_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/qbwt_back.sv
// back part: expands queue entries into result transactions
module qbwt_back import qbwt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qbwt_entry_t head,
	input  logic        empty,
	output logic        pop,
	output logic        valid,
	input  logic        stall,
	output out_item_t   item
);

	logic      out_valid_q;
	out_item_t out_q;
	logic      pend_q;
	logic      pend_quoted_q;
	logic      load;

	// output register free once its transaction is taken
	assign load  = !out_valid_q || !stall;
	assign pop   = load && !pend_q && !empty;
	assign valid = out_valid_q;
	assign item  = out_q;

	// control: output valid and pending token end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= head.has_char && head.has_end;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: character first, token end after it
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q.kind         <= KIND_END;
				out_q.char_out     <= '0;
				out_q.token_quoted <= pend_quoted_q;
				out_q.last_of_run  <= 1'b1;
			end else if (!empty) begin
				pend_quoted_q <= head.quoted;
				if (head.has_char) begin
					out_q.kind         <= KIND_CHAR;
					out_q.char_out     <= head.ch;
					out_q.token_quoted <= 1'b0;
					out_q.last_of_run  <= !head.has_end;
				end else begin
					out_q.kind         <= KIND_END;
					out_q.char_out     <= '0;
					out_q.token_quoted <= head.quoted;
					out_q.last_of_run  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/quoted_brace_word_tokenizer.sv
// Word tokenizer, top level.
// Input channel char_valid / char_stall / char_item: one character of a
// line per transaction, end_of_line set on its last character.
// Output channel tok_valid / tok_stall / tok_item: a kept character
// (kind 0) or a token end (kind 1, token_quoted set when the token used
// quotes or braces); last_of_run marks the final result of one character.
// A character gives zero, one or two results; zero-result characters
// never reach the output.
// A taken character's results pass through the queue, then the output register.
// Throughput: one character per cycle while char_stall is low; a character
// that gives both a kept character and a token end is sent as two
// transactions from the single output register in the back part.
// A two-entry queue sits between the front (grouping state) and the back
// (result expansion); when tok_stall is held the queue fills and then
// char_stall rises. Reset clears grouping state, the queue and the
// output valid flag; the block takes characters from the first cycle after
// reset. Brace nesting saturates at MAX_BRACE_DEPTH.
module quoted_brace_word_tokenizer import qbwt_pkg::*; #(
	parameter int MAX_BRACE_DEPTH = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  in_item_t  char_item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_item
);

	qbwt_entry_t wr_entry, head;
	logic        push, pop, empty, full;

	// classification and grouping state
	qbwt_front #(
		.MAX_BRACE_DEPTH(MAX_BRACE_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (char_valid),
		.stall (char_stall),
		.item  (char_item),
		.full  (full),
		.push  (push),
		.entry (wr_entry)
	);

	// decoupling queue
	qbwt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	// result expansion and output register
	qbwt_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.valid (tok_valid),
		.stall (tok_stall),
		.item  (tok_item)
	);

endmodule

// File: rtl/qbwt_checker.sv
// port-level checker for the word tokenizer and its bind
`include "quoted_brace_word_tokenizer_assert.svh"

module qbwt_checker import qbwt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      char_valid,
	input logic      char_stall,
	input in_item_t  char_item,
	input logic      tok_valid,
	input logic      tok_stall,
	input out_item_t tok_item
);

	logic tok_end, tok_char, split_pending;

	// shorthand views of the result channel
	assign tok_end       = tok_valid && tok_item.kind == KIND_END;
	assign tok_char      = tok_valid && tok_item.kind == KIND_CHAR;
	assign split_pending = tok_char && !tok_stall && !tok_item.last_of_run;

	// a stalled result transaction stays offered
	`QBWT_ASSERT(a_tok_hold, tok_valid && tok_stall |=> tok_valid, "result dropped while stalled")

	// a token end is always the last result of its character
	`QBWT_ASSERT_IMP(a_end_last, tok_end, tok_item.last_of_run, "token end not last of run")

	// a character that is not last of run is followed at once by its token end
	`QBWT_ASSERT(a_end_follows, split_pending |=> tok_end, "token end missing after character")

	// kept characters never carry the quoted flag
	`QBWT_ASSERT_IMP(a_char_unquoted, tok_char, !tok_item.token_quoted, "quoted flag on a character")

endmodule

bind quoted_brace_word_tokenizer qbwt_checker u_qbwt_checker (.*);

// File: tb/sv/tokenizer_result_checker.sv
// watches both channels of the word tokenizer, predicts its results and compares them
module tokenizer_result_checker import qbwt_pkg::*; #(
	parameter int MAX_BRACE_DEPTH = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	input  logic      char_stall,
	input  in_item_t  char_item,
	input  logic      tok_valid,
	input  logic      tok_stall,
	input  out_item_t tok_item,
	output int        failures,
	output int        outstanding
);

	// grouping state of the predicted tokenizer
	logic        in_squote    = 1'b0;
	logic        in_dquote    = 1'b0;
	int unsigned brace_depth  = 0;
	logic        word_open    = 1'b0;
	logic        word_grouped = 1'b0;

	out_item_t expected_tokens[$];
	int        mismatch_count = 0;

	// work out the results of one character and queue them
	function automatic void split_char(in_item_t it);
		logic [7:0] c;
		logic       keep;
		logic       close;
		c = it.char_in;
		keep = 1'b0;
		close = 1'b0;
		if (in_squote) begin
			if (c == CH_SQUOTE) in_squote = 1'b0;
			else keep = 1'b1;
		end else if (in_dquote) begin
			if (c == CH_DQUOTE) in_dquote = 1'b0;
			else keep = 1'b1;
		end else if (brace_depth > 0) begin
			if (c == CH_LBRACE) begin
				// depth saturates, the brace is still kept
				if (brace_depth < MAX_BRACE_DEPTH) brace_depth++;
				keep = 1'b1;
			end else if (c == CH_RBRACE) begin
				brace_depth--;
				keep = (brace_depth > 0);
			end else begin
				keep = 1'b1;
			end
		end else if (c == CH_SQUOTE) begin
			in_squote = 1'b1;
			word_grouped = 1'b1;
			word_open = 1'b1;
		end else if (c == CH_DQUOTE) begin
			in_dquote = 1'b1;
			word_grouped = 1'b1;
			word_open = 1'b1;
		end else if (c == CH_LBRACE) begin
			brace_depth = 1;
			word_grouped = 1'b1;
			word_open = 1'b1;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			close = word_open;
		end else begin
			keep = 1'b1;
			word_open = 1'b1;
		end
		// end of line closes whatever token is pending
		if (it.end_of_line && word_open) close = 1'b1;
		if (keep) expected_tokens.push_back('{KIND_CHAR, c, 1'b0, ~close});
		if (close) begin
			expected_tokens.push_back('{KIND_END, 8'h00, word_grouped, 1'b1});
			word_open = 1'b0;
			word_grouped = 1'b0;
		end
		if (it.end_of_line) begin
			in_squote = 1'b0;
			in_dquote = 1'b0;
			brace_depth = 0;
			word_open = 1'b0;
			word_grouped = 1'b0;
		end
	endfunction

	// compare output transactions, then predict from input transactions
	always @(posedge clk) begin
		out_item_t exp_tok;
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				if (expected_tokens.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: kind=%0d char=%02h quoted=%0d last=%0d",
							tok_item.kind, tok_item.char_out, tok_item.token_quoted,
							tok_item.last_of_run);
				end else begin
					exp_tok = expected_tokens.pop_front();
					if (tok_item.kind !== exp_tok.kind ||
					    tok_item.char_out !== exp_tok.char_out ||
					    tok_item.token_quoted !== exp_tok.token_quoted ||
					    tok_item.last_of_run !== exp_tok.last_of_run) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: expected kind=%0d char=%02h quoted=%0d last=%0d,",
								" got kind=%0d char=%02h quoted=%0d last=%0d"},
								exp_tok.kind, exp_tok.char_out, exp_tok.token_quoted,
								exp_tok.last_of_run, tok_item.kind, tok_item.char_out,
								tok_item.token_quoted, tok_item.last_of_run);
					end
				end
			end
			if (char_valid && !char_stall) split_char(char_item);
		end
		failures <= mismatch_count;
		outstanding <= expected_tokens.size();
	end

endmodule

// File: tb/sv/tb_quoted_brace_word_tokenizer.sv
// stimulus and verdict for the word tokenizer testbench
module tb_quoted_brace_word_tokenizer;
	import qbwt_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	in_item_t  char_item;
	logic      tok_valid;
	logic      tok_stall;
	out_item_t tok_item;

	int failures;
	int outstanding;

	// randomness knobs for sender and receiver, and run counters
	bit sender_idles = 1'b1;
	bit sink_idles   = 1'b1;
	int holds_requested = 0;
	int holds_served    = 0;
	int items_sent      = 0;

	logic [7:0] line_buf[$];

	quoted_brace_word_tokenizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item)
	);

	tokenizer_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_item   (char_item),
		.tok_valid   (tok_valid),
		.tok_stall   (tok_stall),
		.tok_item    (tok_item),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_cycles;
		tok_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served < holds_requested) begin
				hold_cycles = 0;
				while (hold_cycles < 60) begin
					tok_stall <= 1'b1;
					hold_cycles++;
					@(posedge clk);
				end
				holds_served++;
			end
			tok_stall <= sink_idles && ($urandom_range(0, 99) < 11);
		end
	end

	// offer one character and wait until it is taken
	task automatic push_char(input logic [7:0] c, input logic eol);
		while (sender_idles && $urandom_range(0, 99) < 11) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{char_in: c, end_of_line: eol};
		@(posedge clk);
		while (char_stall) @(posedge clk);
		items_sent++;
	endtask

	// send the buffered line, end_of_line on its last character
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			push_char(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
	endtask

	task automatic load_string(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	// any byte, biased toward the grouping and separator characters
	function automatic logic [7:0] random_byte();
		logic [7:0] specials[6];
		specials = '{CH_SPACE, CH_TAB, CH_LBRACE, CH_RBRACE, CH_DQUOTE, CH_SQUOTE};
		if ($urandom_range(0, 2) == 0) return specials[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	// group content that avoids the two given characters
	task automatic add_body(input logic [7:0] avoid_a, input logic [7:0] avoid_b);
		logic [7:0] b;
		repeat ($urandom_range(0, 4)) begin
			b = random_byte();
			if (b == avoid_a || b == avoid_b) b = 8'h61;
			line_buf.push_back(b);
		end
	endtask

	task automatic add_quoted(input logic [7:0] q);
		line_buf.push_back(q);
		add_body(q, q);
		// now and then leave the quote open
		if ($urandom_range(0, 7) != 0) line_buf.push_back(q);
	endtask

	task automatic add_word();
		case ($urandom_range(0, 5))
			0: repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(8'h30, 8'h7A)));
			1: add_quoted(CH_SQUOTE);
			2: add_quoted(CH_DQUOTE);
			3: begin
				line_buf.push_back(CH_LBRACE);
				add_body(CH_LBRACE, CH_RBRACE);
				if ($urandom_range(0, 1) == 1) begin
					line_buf.push_back(CH_LBRACE);
					add_body(CH_LBRACE, CH_RBRACE);
					line_buf.push_back(CH_RBRACE);
					add_body(CH_LBRACE, CH_RBRACE);
				end
				if ($urandom_range(0, 7) != 0) line_buf.push_back(CH_RBRACE);
			end
			4: repeat ($urandom_range(1, 3)) line_buf.push_back(random_byte());
			default: begin
				line_buf.push_back(8'($urandom_range(8'h30, 8'h7A)));
				add_quoted($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
			end
		endcase
	endtask

	task automatic build_random_line();
		repeat ($urandom_range(1, 4)) begin
			add_word();
			repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		end
		// sometimes end the line inside a word rather than on a separator
		if ($urandom_range(0, 1) == 1) add_word();
	endtask

	// stop offering and wait until every predicted result has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int line_no;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_item = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: separator at end of line, empty groups, nesting,
		// quotes in braces, braces in quotes, unterminated quote
		load_string("a\t");
		send_line();
		load_string("'' {}");
		send_line();
		load_string("{a{'\"}}x");
		send_line();
		load_string("\"{ }\"'q");
		send_line();
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);

		// random lines
		line_no = 0;
		while (items_sent < 130 || line_no < 10) begin
			if (line_no == 2) begin
				sender_idles = 1'b0;
				sink_idles = 1'b0;
			end
			if (line_no == 6) begin
				sender_idles = 1'b1;
				sink_idles = 1'b1;
			end
			if (line_no == 7) holds_requested++;
			if (line_no == 9) wait_drained();
			build_random_line();
			send_line();
			line_no++;
		end

		// brace depth runs into saturation, then unwinds a little
		repeat (260) line_buf.push_back(CH_LBRACE);
		line_buf.push_back(8'h7A);
		repeat (3) line_buf.push_back(CH_RBRACE);
		send_line();

		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("tb_quoted_brace_word_tokenizer passed");
		end else begin
			$display("tb_quoted_brace_word_tokenizer failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#(12 * 400000);
		$display("tb_quoted_brace_word_tokenizer failed");
		$finish;
	end

endmodule

// File: quoted_brace_word_tokenizer.f
+incdir+rtl
rtl/qbwt_pkg.sv
rtl/qbwt_front.sv
rtl/qbwt_queue.sv
rtl/qbwt_back.sv
rtl/quoted_brace_word_tokenizer.sv
rtl/qbwt_checker.sv
tb/sv/tokenizer_result_checker.sv
tb/sv/tb_quoted_brace_word_tokenizer.sv
